>>> design/qapm_pkg.sv
// Shared constants, codes and helper functions of the quadcopter attitude PID mixer.
`timescale 1ns / 1ps

package qapm_pkg;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned STICK_W = 10;
  localparam int unsigned REG_W   = 16;

  // Throttle ramp limits and thresholds.
  localparam logic [DUTY_W-1:0]  RAMP_DUTY_MAX = 16'd1000;
  localparam logic [DUTY_W-1:0]  RAMP_DUTY_MIN = 16'd100;
  localparam logic [DUTY_W-1:0]  START_DUTY    = 16'd180;
  localparam logic [STICK_W-1:0] STICK_UP      = 10'd180;
  localparam logic [STICK_W-1:0] STICK_DOWN    = 10'd110;

  // The 120/500 output scale is out*3/3200: floor(floor(3*|out|/128) * 41 / 1024).
  localparam logic signed [16:0] SCALE_RECIP = 17'sd41;
  localparam int unsigned        SCALE_SHIFT = 10;

  typedef enum logic {
    CMD_THROTTLE = 1'b0,
    CMD_ATTITUDE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SETPOINT     = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_OUTPUT_UPPER = 3'd4,
    REG_OUTPUT_LOWER = 3'd5,
    REG_DUTY_UPPER   = 3'd6,
    REG_DUTY_LOWER   = 3'd7
  } reg_index_t;

  // Upper limit is tested first, so crossed limits resolve to the upper one.
  function automatic logic signed [15:0] clamp_q88(input logic signed [27:0] v,
                                                   input logic signed [15:0] upper,
                                                   input logic signed [15:0] lower);
    logic signed [15:0] r;
    if (v > 28'(upper)) begin
      r = upper;
    end else if (v < 28'(lower)) begin
      r = lower;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [DUTY_W-1:0] mix_duty(input logic signed [17:0] t,
                                                 input logic [DUTY_W-1:0] upper,
                                                 input logic [DUTY_W-1:0] lower,
                                                 input logic started);
    logic [DUTY_W-1:0] r;
    if (t > $signed({2'b00, upper})) begin
      r = upper;
    end else if (t < $signed({2'b00, lower}) && started) begin
      r = lower;
    end else if (t < 18'sd0) begin
      r = '0;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

endpackage

>>> design/quad_attitude_pid_mixer_core.sv
// Top level of the quadcopter attitude PID mixer: sequencer, shared multiplier and state.
`timescale 1ns / 1ps

// A throttle beat (tuser 0) ramps the four motor duties; an attitude beat (tuser 1) runs
// the roll and pitch PID loops, scales them by 120/500 and X-mixes them into the duties.
// Every input beat yields exactly one output beat. One signed 17x17 multiplier with a
// registered product is shared by all products. Output valid rises after an attitude beat
// has run four multiplier steps and two add/clamp steps per axis, then a mix and an output
// load, and after a throttle beat has run its ramp step and an output load; the sequencer
// takes no new beat until it is back in idle after that load. s_axis_tready is high
// whenever the sequencer is idle, also while the output register still holds an earlier
// beat; the final load waits only if that earlier beat has not yet been taken.
module quad_attitude_pid_mixer_core
  import qapm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // stick_level[9:0], roll_angle[25:10], pitch_angle[41:26]
  input  logic        s_axis_tuser,   // cmd

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // duty_front_a, duty_front_b, duty_rear_a, duty_rear_b,
                                      // roll_correction, pitch_correction (16 bits each)
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THROTTLE,
    ST_MUL_I,
    ST_MUL_P,
    ST_MUL_D,
    ST_SUM,
    ST_SCALE,
    ST_CORR,
    ST_MIX,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [15:0] setpoint_angle;
  logic [15:0]        gain_p;
  logic [15:0]        gain_i;
  logic [15:0]        gain_d;
  logic signed [15:0] output_upper;
  logic signed [15:0] output_lower;
  logic [15:0]        duty_upper;
  logic [15:0]        duty_lower;

  // Loop state.
  logic [DUTY_W-1:0]  motor_duty [4];
  logic [3:0]         motor_started;
  logic signed [15:0] roll_integral;
  logic signed [15:0] pitch_integral;
  logic signed [15:0] roll_previous;
  logic signed [15:0] pitch_previous;

  // Working registers of one beat.
  logic [STICK_W-1:0] stick;
  logic signed [15:0] roll_in;
  logic signed [15:0] pitch_in;
  logic               axis;          // 0 roll, 1 pitch
  logic signed [33:0] prod;
  logic signed [25:0] pterm;
  logic signed [15:0] out_c;
  logic signed [15:0] roll_corr;
  logic signed [15:0] pitch_corr;
  logic [95:0]        out_data;

  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [15:0] cur_angle;
  logic signed [15:0] cur_integral;
  logic signed [15:0] cur_previous;
  logic signed [16:0] err;
  logic signed [16:0] diff;
  logic signed [25:0] prod_q;
  logic signed [26:0] int_sum;
  logic signed [27:0] out_sum;
  logic signed [15:0] int_clamped;
  logic [16:0]        abs_out;
  logic [17:0]        triple;
  logic [10:0]        scaled;
  logic [4:0]         quot;
  logic signed [15:0] corr;
  logic signed [17:0] mix_t [4];
  logic               out_free;

  assign s_axis_tready = (state == ST_IDLE);

  assign cur_angle    = axis ? pitch_in : roll_in;
  assign cur_integral = axis ? pitch_integral : roll_integral;
  assign cur_previous = axis ? pitch_previous : roll_previous;

  assign err    = 17'(setpoint_angle) - 17'(cur_angle);
  assign diff   = 17'(cur_angle) - 17'(cur_previous);
  assign prod_q = prod[33:8];    // floor of the product over 256

  assign int_sum     = 27'(cur_integral) + 27'(prod_q);
  assign int_clamped = clamp_q88(28'(int_sum), output_upper, output_lower);
  assign out_sum     = 28'(pterm) + 28'(cur_integral) - 28'(prod_q);

  // Magnitude path of the output scaling; the sign is restored after the quotient.
  assign abs_out = out_c[15] ? 17'(-17'(out_c)) : 17'(out_c);
  assign triple  = {1'b0, abs_out} + {abs_out, 1'b0};
  assign scaled  = triple[17:7];
  assign quot    = prod[SCALE_SHIFT+4:SCALE_SHIFT];
  assign corr    = out_c[15] ? -16'(quot) : 16'(quot);

  always_comb begin
    unique case (state)
      ST_MUL_I: begin
        mul_a = 17'({1'b0, gain_i});
        mul_b = err;
      end
      ST_MUL_P: begin
        mul_a = 17'({1'b0, gain_p});
        mul_b = err;
      end
      ST_MUL_D: begin
        mul_a = 17'({1'b0, gain_d});
        mul_b = diff;
      end
      ST_SCALE: begin
        mul_a = SCALE_RECIP;
        mul_b = 17'({1'b0, scaled});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mix_t[0] = 18'({2'b00, motor_duty[0]}) - 18'(roll_corr) - 18'(pitch_corr);
  assign mix_t[1] = 18'({2'b00, motor_duty[1]}) - 18'(roll_corr) + 18'(pitch_corr);
  assign mix_t[2] = 18'({2'b00, motor_duty[2]}) + 18'(roll_corr) + 18'(pitch_corr);
  assign mix_t[3] = 18'({2'b00, motor_duty[3]}) + 18'(roll_corr) - 18'(pitch_corr);

  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign m_axis_tdata = out_data;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (rst) begin
      state          <= ST_IDLE;
      m_axis_tvalid  <= 1'b0;
      setpoint_angle <= '0;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      output_upper   <= 16'sh7FFF;
      output_lower   <= -16'sh8000;
      duty_upper     <= 16'hFFFF;
      duty_lower     <= '0;
      for (int i = 0; i < 4; i++) begin
        motor_duty[i] <= '0;
      end
      motor_started  <= '0;
      roll_integral  <= '0;
      pitch_integral <= '0;
      roll_previous  <= '0;
      pitch_previous <= '0;
      axis           <= 1'b0;
      roll_corr      <= '0;
      pitch_corr     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_SETPOINT:     setpoint_angle <= cfg_data;
          REG_GAIN_P:       gain_p         <= cfg_data;
          REG_GAIN_I:       gain_i         <= cfg_data;
          REG_GAIN_D:       gain_d         <= cfg_data;
          REG_OUTPUT_UPPER: output_upper   <= cfg_data;
          REG_OUTPUT_LOWER: output_lower   <= cfg_data;
          REG_DUTY_UPPER:   duty_upper     <= cfg_data;
          REG_DUTY_LOWER:   duty_lower     <= cfg_data;
        endcase
      end

      // The load step sets valid itself when it replaces a beat being taken.
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            stick      <= s_axis_tdata[9:0];
            roll_in    <= s_axis_tdata[25:10];
            pitch_in   <= s_axis_tdata[41:26];
            axis       <= 1'b0;
            roll_corr  <= '0;
            pitch_corr <= '0;
            state      <= (cmd_t'(s_axis_tuser) == CMD_ATTITUDE) ? ST_MUL_I : ST_THROTTLE;
          end
        end
        ST_THROTTLE: begin
          for (int i = 0; i < 4; i++) begin
            if (stick > STICK_UP && motor_duty[i] <= RAMP_DUTY_MAX) begin
              motor_duty[i] <= motor_duty[i] + 16'd1;
              if (motor_duty[i] + 16'd1 > START_DUTY) begin
                motor_started[i] <= 1'b1;
              end
            end else if (stick < STICK_DOWN && motor_duty[i] >= RAMP_DUTY_MIN) begin
              motor_duty[i] <= motor_duty[i] - 16'd1;
            end
          end
          state <= ST_DONE;
        end
        ST_MUL_I: begin
          state <= ST_MUL_P;
        end
        ST_MUL_P: begin
          if (axis) begin
            pitch_integral <= int_clamped;
          end else begin
            roll_integral <= int_clamped;
          end
          state <= ST_MUL_D;
        end
        ST_MUL_D: begin
          pterm <= prod_q;
          state <= ST_SUM;
        end
        ST_SUM: begin
          out_c <= clamp_q88(out_sum, output_upper, output_lower);
          if (axis) begin
            pitch_previous <= cur_angle;
          end else begin
            roll_previous <= cur_angle;
          end
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_CORR;
        end
        ST_CORR: begin
          if (axis) begin
            pitch_corr <= corr;
            state      <= ST_MIX;
          end else begin
            roll_corr <= corr;
            axis      <= 1'b1;
            state     <= ST_MUL_I;
          end
        end
        ST_MIX: begin
          for (int i = 0; i < 4; i++) begin
            motor_duty[i] <= mix_duty(mix_t[i], duty_upper, duty_lower, motor_started[i]);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data      <= {pitch_corr, roll_corr, motor_duty[3], motor_duty[2],
                              motor_duty[1], motor_duty[0]};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end else if (m_axis_tvalid && m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A started motor stays started until reset.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((motor_started & $past(motor_started)) == $past(motor_started)))
    else $error("motor started flag dropped without reset");

  // Output beats are only produced by the final load step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DONE))
    else $error("output valid raised outside the load step");

  // Scaled corrections of a clamped Q8.8 output never exceed 30 duty counts.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[79:64]) <= 16'sd30 &&
                       $signed(m_axis_tdata[79:64]) >= -16'sd30 &&
                       $signed(m_axis_tdata[95:80]) <= 16'sd30 &&
                       $signed(m_axis_tdata[95:80]) >= -16'sd30))
    else $error("correction out of range");

  // An accepted beat starts either the throttle step or the first roll product.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_THROTTLE ||
                                          (state == ST_MUL_I && axis == 1'b0)))
    else $error("accepted beat did not start a sequence");

endmodule
